// ===== design/spcd_pkg.sv =====
// Shared constants, codes and types of the square-pulse correlation detector.
package spcd_pkg;

	localparam int PEAK_BITS     = 24;
	localparam int THR_BITS      = 17;
	localparam int MINP_BITS     = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int FRAME_BITS    = 32;
	localparam int FRAC_SHIFT    = 32;
	localparam int MUL_OP_BITS   = 34;
	localparam int IN_DATA_BITS  = 32;
	localparam int OUT_DATA_BITS = 88;

	localparam logic [THR_BITS-1:0]   THR_RESET  = 17'd16384;
	localparam logic [MINP_BITS-1:0]  MINP_RESET = 24'd4194;
	localparam logic [PEAK_BITS-1:0]  PEAK_MAX   = 24'hFF_FFFF;
	localparam logic [FRAME_BITS-1:0] FRAME_MAX  = 32'hFFFF_FFFF;

	typedef enum logic [0:0] {
		CFG_DETECT_THRESHOLD = 1'b0,
		CFG_MIN_PEAK         = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_TT,
		ST_TW,
		ST_SQ,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic done;
		logic ge;
	} cmp_stat_t;

endpackage

// ===== design/spcd_sqcmp.sv =====
// Bit-serial compare of (S*S << 32) against E*TW, one multiplier bit per cycle.
module spcd_sqcmp
	import spcd_pkg::*;
#(
	parameter int SW  = 33,
	parameter int EW  = 57,
	parameter int TWW = 43,
	parameter int CW  = 101,
	parameter int NB  = 43
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [SW-1:0]  s_mag,
	input  logic [EW-1:0]  energy,
	input  logic [TWW-1:0] tw,
	output cmp_stat_t      stat
);

	localparam int NBW = $clog2(NB + 1);

	logic [CW-1:0]  lsh_q, rsh_q, lacc_q, racc_q;
	logic [SW-1:0]  lmul_q;
	logic [TWW-1:0] rmul_q;
	logic [NBW-1:0] bit_q;
	logic           busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + NBW'(1);
				if (bit_q == NBW'(NB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Both products advance together: each accumulator adds its shifted multiplicand
	// when the current multiplier bit is set.
	always_ff @(posedge clk) begin
		if (start) begin
			lsh_q  <= CW'(s_mag) << FRAC_SHIFT;
			rsh_q  <= CW'(energy);
			lmul_q <= s_mag;
			rmul_q <= tw;
			lacc_q <= '0;
			racc_q <= '0;
		end else if (busy_q) begin
			if (lmul_q[0]) begin
				lacc_q <= lacc_q + lsh_q;
			end
			if (rmul_q[0]) begin
				racc_q <= racc_q + rsh_q;
			end
			lsh_q  <= lsh_q << 1;
			rsh_q  <= rsh_q << 1;
			lmul_q <= lmul_q >> 1;
			rmul_q <= rmul_q >> 1;
		end
	end

	assign stat.done = done_q;
	assign stat.ge   = (lacc_q >= racc_q);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("compare started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("compare done without a run");

	a_racc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start) |=> (racc_q >= $past(racc_q)))
		else $error("energy product accumulator decreased");

endmodule

// ===== design/square_pulse_correlation_detector.sv =====
// Top level of the square-pulse correlation detector.
// While armed and before a detection, every sample request is written into a
// window memory of WINDOW entries and updates the running peak. Once WINDOW
// samples have arrived, the request walks the whole window oldest first, one
// memory read per cycle through a single registered multiplier that forms the
// squares, then the same multiplier forms threshold squared times WINDOW, and a
// bit-serial unit compares (S*S << 32) with that value times the energy, over
// NB = max(SAMPLE_BITS, 34) + clog2(WINDOW) multiplier bits. A request that is
// not armed, that comes after a detection, or that arrives before the window is
// full skips the walk; when the window fails the peak, energy or sign test the
// compare is skipped. Input is refused while a request is in work; a finished
// result waits in the output register while the next request is taken. The
// window memory needs no clearing after reset, since it is only read once every
// entry has been written.
module square_pulse_correlation_detector
	import spcd_pkg::*;
#(
	parameter int WINDOW      = 512,
	parameter int HALF_PERIOD = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [23:0] sample
	input  logic [0:0]               s_tuser,   // [0] armed
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [0] detect_now, [1] detect_done, [33:2] window_start, [57:34] window_peak,
	// [81:58] running_peak
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int SB   = SAMPLE_BITS;
	localparam int AW   = $clog2(WINDOW);
	localparam int HPW  = (HALF_PERIOD > 1) ? $clog2(HALF_PERIOD) : 1;
	localparam int SQW  = 2 * SB;
	localparam int EW   = SQW + AW;
	localparam int DW   = SB + AW + 1;
	localparam int SW   = SB + AW;
	localparam int TWW  = MUL_OP_BITS + AW;
	localparam int CW   = 2 * SB + 2 * AW + 35;
	localparam int NB   = (SW > TWW) ? SW : TWW;
	localparam int XW   = (SB > PEAK_BITS) ? SB : PEAK_BITS;
	localparam int MULW = 2 * MUL_OP_BITS;
	localparam logic [AW:0]  WIN_C = (AW + 1)'(WINDOW);
	localparam logic [XW-1:0] PEAK_MAX_X = XW'(PEAK_MAX);

	state_t state_q, state_d;

	logic [23:0]            sample_q;
	logic                   armed_q;
	logic [SB-1:0]          win_mem [WINDOW];
	logic [SB-1:0]          rdata_s1;
	logic                   v_s1, neg_s1, v_s2, neg_s2;
	logic [SB-1:0]          val_s2, mag_s2;
	logic [MULW-1:0]        mul_q;
	logic [MUL_OP_BITS-1:0] mul_a, mul_b;
	logic [AW-1:0]          wr_ptr_q, rd_idx_q;
	logic [AW:0]            cnt_q;
	logic [HPW-1:0]         hp_q;
	logic                   phase_q;
	logic [FRAME_BITS-1:0]  frame_q, frame_next;
	logic [PEAK_BITS-1:0]   seen_q, fpeak_q;
	logic [FRAME_BITS-1:0]  fstart_q;
	logic                   found_q, now_q;
	logic [EW-1:0]          energy_q;
	logic signed [DW-1:0]   dot_q;
	logic [SB-1:0]          wpeak_q;
	logic [THR_BITS-1:0]    thr_q;
	logic [MINP_BITS-1:0]   minp_q;
	logic                   m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;

	logic [XW-1:0]          raw_x;
	logic [SB-1:0]          raw, mag_in, mag_s1;
	logic [XW-1:0]          mag_in_x, wpeak_x;
	logic [PEAK_BITS-1:0]   sat_in, sat_wpeak;
	logic [AW-1:0]          wr_next, rd_next;
	logic                   act, win_full, pre_ok, issue, walk_end;
	logic                   mem_we, cmp_start, out_load, in_take;
	cmp_stat_t              cmp_stat;

	// Sample decode: the low SAMPLE_BITS bits are two's complement.
	assign raw_x    = XW'(sample_q);
	assign raw      = raw_x[SB-1:0];
	assign mag_in   = raw[SB-1] ? (~raw + SB'(1)) : raw;
	assign mag_in_x = XW'(mag_in);
	assign sat_in   = (mag_in_x > PEAK_MAX_X) ? PEAK_MAX : mag_in_x[PEAK_BITS-1:0];
	assign wpeak_x  = XW'(wpeak_q);
	assign sat_wpeak = (wpeak_x > PEAK_MAX_X) ? PEAK_MAX : wpeak_x[PEAK_BITS-1:0];

	assign act        = armed_q && !found_q;
	assign frame_next = (frame_q == FRAME_MAX) ? frame_q : frame_q + FRAME_BITS'(1);
	assign win_full   = (frame_next >= FRAME_BITS'(WINDOW));
	assign wr_next    = (({1'b0, wr_ptr_q} + (AW + 1)'(1)) == WIN_C) ? '0 : wr_ptr_q + AW'(1);
	assign rd_next    = (({1'b0, rd_idx_q} + (AW + 1)'(1)) == WIN_C) ? '0 : rd_idx_q + AW'(1);

	assign issue    = (state_q == ST_WALK) && (cnt_q != WIN_C);
	assign walk_end = (state_q == ST_WALK) && (cnt_q == WIN_C) && !v_s1 && !v_s2;
	assign pre_ok   = (wpeak_x >= XW'(minp_q)) && (energy_q != '0) &&
	                  !dot_q[DW-1] && (dot_q != '0);

	assign mag_s1 = rdata_s1[SB-1] ? (~rdata_s1 + SB'(1)) : rdata_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_LOAD;
			ST_LOAD: state_d = (act && win_full) ? ST_WALK : ST_EMIT;
			ST_WALK: if (walk_end) state_d = ST_TT;
			ST_TT:   state_d = pre_ok ? ST_TW : ST_EMIT;
			ST_TW:   state_d = ST_SQ;
			ST_SQ:   state_d = ST_WAIT;
			ST_WAIT: if (cmp_stat.done) state_d = ST_EMIT;
			ST_EMIT: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		cmp_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_LOAD: mem_we    = act;
			ST_SQ:   cmp_start = 1'b1;
			ST_EMIT: out_load  = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	assign in_take = s_tvalid && s_tready;

	// One multiplier: window squares during the walk, then t*t and t*t*WINDOW.
	always_comb begin
		unique case (state_q)
			ST_TT: begin
				mul_a = MUL_OP_BITS'(thr_q);
				mul_b = MUL_OP_BITS'(thr_q);
			end
			ST_TW: begin
				mul_a = mul_q[MUL_OP_BITS-1:0];
				mul_b = MUL_OP_BITS'(WINDOW);
			end
			default: begin
				mul_a = MUL_OP_BITS'(mag_s1);
				mul_b = MUL_OP_BITS'(mag_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[wr_ptr_q] <= raw;
		end
		rdata_s1 <= win_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= s_tdata[23:0];
		end
		val_s2 <= rdata_s1;
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			armed_q  <= 1'b0;
			thr_q    <= THR_RESET;
			minp_q   <= MINP_RESET;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				armed_q <= s_tuser[0];
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_DETECT_THRESHOLD: thr_q  <= cfg_data[THR_BITS-1:0];
					CFG_MIN_PEAK:         minp_q <= cfg_data[MINP_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	// Window walk: read issue, then square, then accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_idx_q <= '0;
			cnt_q    <= '0;
			hp_q     <= '0;
			phase_q  <= 1'b0;
			v_s1     <= 1'b0;
			neg_s1   <= 1'b0;
			v_s2     <= 1'b0;
			frame_q  <= '0;
			seen_q   <= '0;
			energy_q <= '0;
			dot_q    <= '0;
			wpeak_q  <= '0;
		end else begin
			v_s1   <= issue;
			neg_s1 <= phase_q;
			v_s2   <= v_s1;
			if (state_q == ST_LOAD && act) begin
				if (sat_in > seen_q) begin
					seen_q <= sat_in;
				end
				wr_ptr_q <= wr_next;
				frame_q  <= frame_next;
				rd_idx_q <= wr_next;
				cnt_q    <= '0;
				hp_q     <= '0;
				phase_q  <= 1'b0;
				energy_q <= '0;
				dot_q    <= '0;
				wpeak_q  <= '0;
			end
			if (issue) begin
				rd_idx_q <= rd_next;
				cnt_q    <= cnt_q + (AW + 1)'(1);
				if (hp_q == HPW'(HALF_PERIOD - 1)) begin
					hp_q    <= '0;
					phase_q <= !phase_q;
				end else begin
					hp_q <= hp_q + HPW'(1);
				end
			end
			if (v_s2) begin
				energy_q <= energy_q + EW'(mul_q[SQW-1:0]);
				dot_q    <= neg_s2 ? dot_q - DW'($signed(val_s2))
				                   : dot_q + DW'($signed(val_s2));
				if (mag_s2 > wpeak_q) begin
					wpeak_q <= mag_s2;
				end
			end
		end
	end

	spcd_sqcmp #(
		.SW  (SW),
		.EW  (EW),
		.TWW (TWW),
		.CW  (CW),
		.NB  (NB)
	) u_sqcmp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_start),
		.s_mag  (dot_q[SW-1:0]),
		.energy (energy_q),
		.tw     (mul_q[TWW-1:0]),
		.stat   (cmp_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			fstart_q <= '0;
			fpeak_q  <= '0;
			now_q    <= 1'b0;
		end else begin
			if (state_q == ST_LOAD) begin
				now_q <= 1'b0;
			end
			if (state_q == ST_WAIT && cmp_stat.done && cmp_stat.ge) begin
				found_q  <= 1'b1;
				fstart_q <= frame_q - FRAME_BITS'(WINDOW);
				fpeak_q  <= sat_wpeak;
				now_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {6'b0, seen_q, fpeak_q, fstart_q, found_q, now_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |=> found_q)
		else $error("detection flag dropped");

	a_walk_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (frame_q >= FRAME_BITS'(WINDOW)))
		else $error("window walked before it was full");

	a_now_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> m_tdata[1])
		else $error("detection result without the sticky flag");

	a_seen_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (seen_q >= $past(seen_q)))
		else $error("running peak decreased");

endmodule

// ===== dv/square_pulse_correlation_detector_tb.sv =====
// Self-checking testbench of the square-pulse correlation detector: directed table, random waves.
module square_pulse_correlation_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spcd_pkg::*;

	localparam int WIN_LEN    = 512;
	localparam int HALF_LEN   = 8;
	localparam int SAMPLE_W   = 24;
	localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

	typedef struct packed {
		logic [PEAK_BITS-1:0]  running_peak;
		logic [PEAK_BITS-1:0]  window_peak;
		logic [FRAME_BITS-1:0] window_start;
		logic                  detect_done;
		logic                  detect_now;
	} verdict_t;

	localparam int VERDICT_BITS = $bits(verdict_t);

	typedef enum {WAVE_SQUARE, WAVE_DC, WAVE_NOISE, WAVE_EXTREME} waveform_t;

	typedef struct {
		int          smp;
		bit          armed;
		bit          typed;
		int unsigned peak;
	} probe_t;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
	logic [0:0]               s_tuser   = '0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     cfg_we    = 1'b0;
	logic [0:0]               cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	square_pulse_correlation_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Detector state as the block should hold it.
	int                    win_hist [WIN_LEN];
	int                    win_wr       = 0;
	logic [FRAME_BITS-1:0] frames_taken = '0;
	logic [PEAK_BITS-1:0]  peak_seen    = '0;
	logic                  hit_flag     = 1'b0;
	logic [FRAME_BITS-1:0] hit_start    = '0;
	logic [PEAK_BITS-1:0]  hit_peak     = '0;
	logic [THR_BITS-1:0]   thr_cfg      = THR_RESET;
	logic [MINP_BITS-1:0]  minp_cfg     = MINP_RESET;

	verdict_t verdicts_due [$];
	int       mismatch_count = 0;
	int       send_gap_pct   = 0;
	int       stall_pct      = 0;

	waveform_t   wave        = WAVE_SQUARE;
	int          wave_left   = 0;
	int          wave_amp    = 1;
	int          wave_noise  = 0;
	int          wave_level  = 0;
	int unsigned square_tick = 0;

	// Before the window is full only the running peak moves, so those rows are typed in.
	probe_t probes [0:19] = '{
		'{1193046,    1'b0, 1'b1, 0},
		'{0,          1'b1, 1'b1, 0},
		'{1,          1'b1, 1'b1, 1},
		'{-1,         1'b1, 1'b1, 1},
		'{SAMPLE_MAX, 1'b0, 1'b1, 1},
		'{SAMPLE_MAX, 1'b1, 1'b1, 8388607},
		'{SAMPLE_MIN, 1'b0, 1'b1, 8388607},
		'{SAMPLE_MIN, 1'b1, 1'b1, 8388608},
		'{-8388607,   1'b1, 1'b1, 8388608},
		'{5592405,    1'b1, 1'b1, 8388608},
		'{-5592406,   1'b1, 1'b0, 0},
		'{4194,       1'b1, 1'b1, 8388608},
		'{-4194,      1'b1, 1'b1, 8388608},
		'{4193,       1'b1, 1'b0, 0},
		'{1048576,    1'b1, 1'b0, 0},
		'{-2097152,   1'b1, 1'b0, 0},
		'{0,          1'b0, 1'b1, 8388608},
		'{12345,      1'b1, 1'b0, 0},
		'{SAMPLE_MIN, 1'b1, 1'b1, 8388608},
		'{SAMPLE_MAX, 1'b1, 1'b1, 8388608}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic report_mismatch(string what, logic [OUT_DATA_BITS-1:0] got,
			logic [OUT_DATA_BITS-1:0] want);
		$display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
		mismatch_count++;
	endtask

	// Advances the detector state by one accepted request and returns its result.
	function automatic verdict_t score_sample(logic [SAMPLE_W-1:0] smp, logic armed);
		int                val;
		int unsigned       mag;
		longint            dot;
		longint unsigned   energy;
		longint unsigned   wpeak;
		longint unsigned   amp;
		longint unsigned   tt;
		bit [127:0]        lhs;
		bit [127:0]        rhs;
		int                idx;
		int                p;
		verdict_t          v;
		v = '0;
		if (armed && !hit_flag) begin
			val = int'($signed(smp));
			mag = (val < 0) ? -val : val;
			if (mag > peak_seen)
				peak_seen = mag[PEAK_BITS-1:0];
			win_hist[win_wr] = val;
			win_wr = (win_wr == WIN_LEN - 1) ? 0 : win_wr + 1;
			if (frames_taken != FRAME_MAX)
				frames_taken++;
			if (frames_taken >= WIN_LEN) begin
				dot = 0;
				energy = 0;
				wpeak = 0;
				idx = win_wr;
				for (p = 0; p < WIN_LEN; p++) begin
					amp = 64'((win_hist[idx] < 0) ? -win_hist[idx] : win_hist[idx]);
					if (amp > wpeak)
						wpeak = amp;
					if (((p / HALF_LEN) % 2) == 0)
						dot += longint'(win_hist[idx]);
					else
						dot -= longint'(win_hist[idx]);
					energy += amp * amp;
					idx = (idx == WIN_LEN - 1) ? 0 : idx + 1;
				end
				// Root-free score test: S*S << 32 against threshold^2 * WINDOW * energy.
				if (wpeak >= minp_cfg && energy != 0 && dot > 0) begin
					tt = 64'(thr_cfg);
					tt = tt * tt * 64'(WIN_LEN);
					lhs = {64'd0, dot};
					lhs = (lhs * lhs) << FRAC_SHIFT;
					rhs = {64'd0, energy} * {64'd0, tt};
					if (lhs >= rhs) begin
						hit_flag = 1'b1;
						hit_start = frames_taken - FRAME_BITS'(WIN_LEN);
						hit_peak = wpeak[PEAK_BITS-1:0];
						v.detect_now = 1'b1;
					end
				end
			end
		end
		v.detect_done = hit_flag;
		v.window_start = hit_start;
		v.window_peak = hit_peak;
		v.running_peak = peak_seen;
		return v;
	endfunction

	function automatic int random_sample();
		logic [SAMPLE_W-1:0] r;
		r = SAMPLE_W'($urandom);
		return int'($signed(r));
	endfunction

	// Waves come in stretches; square stretches share one phase so the window stays coherent.
	task automatic next_stimulus(input int square_pct, output logic [SAMPLE_W-1:0] smp,
			output logic armed);
		int v;
		if (wave_left == 0) begin
			if ($urandom_range(0, 99) < square_pct) begin
				wave = WAVE_SQUARE;
			end else begin
				case ($urandom_range(0, 2))
					0: wave = WAVE_DC;
					1: wave = WAVE_NOISE;
					default: wave = WAVE_EXTREME;
				endcase
			end
			wave_left = $urandom_range(4, 60);
			wave_amp = $urandom_range(1, SAMPLE_MAX);
			wave_noise = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, wave_amp / 4);
			wave_level = random_sample();
		end
		wave_left--;
		case (wave)
			WAVE_SQUARE: begin
				v = (((square_tick / HALF_LEN) % 2) == 0) ? wave_amp : -wave_amp;
				v = v + int'($urandom_range(0, 2 * wave_noise)) - wave_noise;
			end
			WAVE_DC: v = wave_level;
			WAVE_NOISE: v = random_sample();
			default: begin
				case ($urandom_range(0, 4))
					0: v = SAMPLE_MIN;
					1: v = SAMPLE_MAX;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
		endcase
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			v = SAMPLE_MIN;
		smp = v[SAMPLE_W-1:0];
		armed = ($urandom_range(0, 99) >= 6);
		if (armed)
			square_tick++;
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic armed);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {{(IN_DATA_BITS - SAMPLE_W){1'b0}}, smp};
		s_tuser <= armed;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic feed_one(int square_pct);
		logic [SAMPLE_W-1:0] smp;
		logic                armed;
		next_stimulus(square_pct, smp, armed);
		send_sample(smp, armed);
		verdicts_due.push_back(score_sample(smp, armed));
	endtask

	task automatic run_phase(int n_items, int square_pct);
		repeat (n_items)
			feed_one(square_pct);
	endtask

	// Every request yields one result, so an empty queue means the block is idle.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DETECT_THRESHOLD: thr_cfg = val[THR_BITS-1:0];
			CFG_MIN_PEAK: minp_cfg = val[MINP_BITS-1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[VERDICT_BITS-1:0];
			if (verdicts_due.size() == 0) begin
				report_mismatch("result with no request pending", m_tdata, '0);
			end else begin
				want = verdicts_due.pop_front();
				if (got.detect_now !== want.detect_now)
					report_mismatch("detect_now", OUT_DATA_BITS'(got.detect_now),
						OUT_DATA_BITS'(want.detect_now));
				if (got.detect_done !== want.detect_done)
					report_mismatch("detect_done", OUT_DATA_BITS'(got.detect_done),
						OUT_DATA_BITS'(want.detect_done));
				if (got.window_start !== want.window_start)
					report_mismatch("window_start", OUT_DATA_BITS'(got.window_start),
						OUT_DATA_BITS'(want.window_start));
				if (got.window_peak !== want.window_peak)
					report_mismatch("window_peak", OUT_DATA_BITS'(got.window_peak),
						OUT_DATA_BITS'(want.window_peak));
				if (got.running_peak !== want.running_peak)
					report_mismatch("running_peak", OUT_DATA_BITS'(got.running_peak),
						OUT_DATA_BITS'(want.running_peak));
				if (m_tdata[OUT_DATA_BITS-1:VERDICT_BITS] !== '0)
					report_mismatch("pad bits",
						OUT_DATA_BITS'(m_tdata[OUT_DATA_BITS-1:VERDICT_BITS]), '0);
			end
		end
	end

	initial begin
		verdict_t            typed_v;
		logic [SAMPLE_W-1:0] smp;
		foreach (win_hist[i])
			win_hist[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows at the reset register values.
		foreach (probes[i]) begin
			smp = probes[i].smp[SAMPLE_W-1:0];
			send_sample(smp, probes[i].armed);
			typed_v = score_sample(smp, probes[i].armed);
			if (probes[i].typed) begin
				typed_v = '0;
				typed_v.running_peak = probes[i].peak[PEAK_BITS-1:0];
			end
			verdicts_due.push_back(typed_v);
		end
		drain();

		// A threshold above 1.0 can never detect, so the window fills safely.
		write_reg(CFG_DETECT_THRESHOLD, 24'd131071);
		write_reg(CFG_MIN_PEAK, 24'd0);
		while (frames_taken < WIN_LEN)
			feed_one(70);
		drain();

		write_reg(CFG_DETECT_THRESHOLD, 24'd65536);
		write_reg(CFG_MIN_PEAK, 24'd8388608);
		send_gap_pct = 65;
		run_phase(10, 80);
		drain();

		// The peak can never reach this minimum, whatever the zero threshold allows.
		write_reg(CFG_DETECT_THRESHOLD, 24'd0);
		write_reg(CFG_MIN_PEAK, 24'hFF_FFFF);
		send_gap_pct = 0;
		stall_pct = 65;
		run_phase(10, 80);
		drain();

		write_reg(CFG_DETECT_THRESHOLD, 24'($urandom_range(4096, 30000)));
		write_reg(CFG_MIN_PEAK, 24'($urandom_range(1, 100000)));
		send_gap_pct = 38;
		stall_pct = 38;
		run_phase(12, 85);
		drain();

		repeat (600) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/spcd_pkg.sv
design/spcd_sqcmp.sv
design/square_pulse_correlation_detector.sv
dv/square_pulse_correlation_detector_tb.sv
